@@ rtl/dcbf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dcbf_pkg;

   // Coordinate deltas are scaled up by this many bits before being summed.
   localparam int unsigned COORD_SHIFT = 5;
   localparam int unsigned COORD_W     = 32;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned VARINT_MAX  = 10;   // bytes in the longest legal varint
   localparam int unsigned VCNT_W      = 4;
   localparam int unsigned RSP_DATA_W  = 72;   // point_x, point_y, two flags, padding

   localparam logic [COORD_W-1:0] ORIGIN_MASK = ~((COORD_W'(1) << COORD_SHIFT) - COORD_W'(1));
   localparam logic signed [COORD_W-1:0] MIN_INIT = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] MAX_INIT = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUERY_LEFT   = 3'd0,
      CSR_QUERY_RIGHT  = 3'd1,
      CSR_QUERY_TOP    = 3'd2,
      CSR_QUERY_BOTTOM = 3'd3,
      CSR_ORIGIN_X     = 3'd4,
      CSR_ORIGIN_Y     = 3'd5
   } csr_index_type;

   // Decode stage output, handed to the verdict / output stage.
   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic                      pt_valid;
      logic                      done;
      logic                      found;
      logic                      err;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_y;
   } dec_beat_type;

endpackage

`default_nettype wire

@@ rtl/delta_coordinate_box_filter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | dir | handshake             | payload
// --------+-----+-----------------------+-----------------------------------------------
// req     | in  | req_tvalid/req_tready | tdata[7:0] payload_byte, tlast final_byte
// rsp     | out | rsp_tvalid/rsp_tready | tdata x,y,inside,err; tuser point_valid;
//         |     |                       | tlast object_done
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data (32-bit register write)
//
// One byte per clock sustained while rsp does not stall. The varint/zigzag/
// add and point compares update the decode state in the accept cycle; the
// box-overlap verdict is formed from stage 1 and registered into rsp.
// Bytes that complete no point and are not final produce no beat.
// reset is synchronous, active high; it clears the config registers and the
// decode state. A stalled rsp backs up through the two stages to req_tready.

module delta_coordinate_box_filter_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request: tdata = payload_byte[7:0]
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,
   input  wire logic                           req_tlast,
   // response: tdata = point_x[31:0], point_y[63:32], inside_query[64],
   //           decode_error[65], zero [71:66]; tuser = point_valid
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [dcbf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic                           rsp_tuser,
   output      logic                           rsp_tlast,
   // register write port
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [dcbf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dcbf_pkg::COORD_W-1:0]    csr_data
);

   import dcbf_pkg::*;

   // ---------------- configuration ----------------
   logic signed [COORD_W-1:0] q_left_ff, q_right_ff, q_top_ff, q_bottom_ff;
   logic        [COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic                      csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_left_ff   <= '0;
         q_right_ff  <= '0;
         q_top_ff    <= '0;
         q_bottom_ff <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_QUERY_LEFT:   q_left_ff   <= csr_data;
            CSR_QUERY_RIGHT:  q_right_ff  <= csr_data;
            CSR_QUERY_TOP:    q_top_ff    <= csr_data;
            CSR_QUERY_BOTTOM: q_bottom_ff <= csr_data;
            CSR_ORIGIN_X:     origin_x_ff <= csr_data;
            CSR_ORIGIN_Y:     origin_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline handshake ----------------
   dec_beat_type s1_ff, s1_in;
   logic         s1_valid_ff, s1_valid_in;
   logic         s2_ready, s1_ready, req_acc;

   assign s2_ready   = !rsp_tvalid || rsp_tready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_acc    = req_tvalid && req_tready;

   // ---------------- decode state ----------------
   logic [COORD_W-1:0]        accum_ff, accum_in;
   logic [VCNT_W-1:0]         vcnt_ff, vcnt_in;
   logic                      expect_y_ff, expect_y_in;
   logic [COORD_W-1:0]        pending_x_ff, pending_x_in;
   logic [COORD_W-1:0]        prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                      found_ff, found_in;
   logic signed [COORD_W-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [COORD_W-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic                      overlong_ff, overlong_in;

   // byte decode
   logic [COORD_W-1:0]        contrib, acc_or, zz, delta, sum_x, sum_y;
   logic [VCNT_W-1:0]         cnt_inc;
   logic                      cont, value_done, pt_valid, in_box, upd_box;
   logic signed [COORD_W-1:0] sx, sy;
   // state after this byte, before the end-of-object clear
   logic [COORD_W-1:0]        u_accum, u_pend, u_prev_x, u_prev_y;
   logic [VCNT_W-1:0]         u_vcnt;
   logic                      u_expect_y, u_found, u_overlong;
   logic signed [COORD_W-1:0] u_min_x, u_max_x, u_min_y, u_max_y;

   always_comb begin
      // 7 payload bits per byte, little-endian; the fifth byte only reaches
      // bits 31:28 and anything past it is dropped.
      case (vcnt_ff)
         4'd0:    contrib = {25'd0, req_tdata[6:0]};
         4'd1:    contrib = {18'd0, req_tdata[6:0], 7'd0};
         4'd2:    contrib = {11'd0, req_tdata[6:0], 14'd0};
         4'd3:    contrib = {4'd0, req_tdata[6:0], 21'd0};
         4'd4:    contrib = {req_tdata[3:0], 28'd0};
         default: contrib = '0;
      endcase
      acc_or     = accum_ff | contrib;
      cont       = req_tdata[7];
      cnt_inc    = vcnt_ff + VCNT_W'(1);
      value_done = !overlong_ff && !cont;
      pt_valid   = value_done && expect_y_ff;

      // zigzag (sint32) then scale
      zz    = {1'b0, acc_or[COORD_W-1:1]} ^ {COORD_W{acc_or[0]}};
      delta = zz << COORD_SHIFT;
      sum_x = delta + prev_x_ff;
      sum_y = delta + prev_y_ff;

      sx = pending_x_ff;
      sy = sum_y;
      in_box = (q_left_ff <= sx) && (q_right_ff >= sx) &&
               (q_top_ff <= sy) && (q_bottom_ff >= sy);

      u_accum    = accum_ff;
      u_vcnt     = vcnt_ff;
      u_expect_y = expect_y_ff;
      u_pend     = pending_x_ff;
      u_prev_x   = prev_x_ff;
      u_prev_y   = prev_y_ff;
      u_overlong = overlong_ff;
      u_found    = found_ff;

      if (!overlong_ff) begin
         if (cont) begin
            if (cnt_inc >= VCNT_W'(VARINT_MAX)) begin
               u_overlong = 1'b1;
               u_vcnt     = '0;
               u_accum    = '0;
            end else begin
               u_vcnt  = cnt_inc;
               u_accum = acc_or;
            end
         end else begin
            u_accum = '0;
            u_vcnt  = '0;
            if (!expect_y_ff) begin
               u_pend     = sum_x;
               u_expect_y = 1'b1;
            end else begin
               u_prev_x   = pending_x_ff;
               u_prev_y   = sum_y;
               u_expect_y = 1'b0;
            end
         end
      end

      if (pt_valid && in_box)
         u_found = 1'b1;

      // bounding box only grows while nothing has landed inside
      upd_box = pt_valid && !u_found;
      u_min_x = (upd_box && sx < min_x_ff) ? sx : min_x_ff;
      u_max_x = (upd_box && sx > max_x_ff) ? sx : max_x_ff;
      u_min_y = (upd_box && sy < min_y_ff) ? sy : min_y_ff;
      u_max_y = (upd_box && sy > max_y_ff) ? sy : max_y_ff;

      // beat handed to the verdict stage
      s1_in.px       = pt_valid ? sx : '0;
      s1_in.py       = pt_valid ? sy : '0;
      s1_in.pt_valid = pt_valid;
      s1_in.done     = req_tlast;
      s1_in.found    = u_found;
      s1_in.err      = u_overlong || (u_vcnt != '0) || u_expect_y;
      s1_in.min_x    = u_min_x;
      s1_in.max_x    = u_max_x;
      s1_in.min_y    = u_min_y;
      s1_in.max_y    = u_max_y;

      // next state: hold, take the byte, or clear at end of object
      accum_in     = accum_ff;
      vcnt_in      = vcnt_ff;
      expect_y_in  = expect_y_ff;
      pending_x_in = pending_x_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      found_in     = found_ff;
      min_x_in     = min_x_ff;
      max_x_in     = max_x_ff;
      min_y_in     = min_y_ff;
      max_y_in     = max_y_ff;
      overlong_in  = overlong_ff;

      if (req_acc) begin
         if (req_tlast) begin
            accum_in     = '0;
            vcnt_in      = '0;
            expect_y_in  = 1'b0;
            pending_x_in = '0;
            prev_x_in    = origin_x_ff & ORIGIN_MASK;
            prev_y_in    = origin_y_ff & ORIGIN_MASK;
            found_in     = 1'b0;
            min_x_in     = MIN_INIT;
            max_x_in     = MAX_INIT;
            min_y_in     = MIN_INIT;
            max_y_in     = MAX_INIT;
            overlong_in  = 1'b0;
         end else begin
            accum_in     = u_accum;
            vcnt_in      = u_vcnt;
            expect_y_in  = u_expect_y;
            pending_x_in = u_pend;
            prev_x_in    = u_prev_x;
            prev_y_in    = u_prev_y;
            found_in     = u_found;
            min_x_in     = u_min_x;
            max_x_in     = u_max_x;
            min_y_in     = u_min_y;
            max_y_in     = u_max_y;
            overlong_in  = u_overlong;
         end
      end

      // an origin write restarts the running point right away
      if (csr_wr && csr_index == CSR_ORIGIN_X)
         prev_x_in = csr_data & ORIGIN_MASK;
      if (csr_wr && csr_index == CSR_ORIGIN_Y)
         prev_y_in = csr_data & ORIGIN_MASK;

      // stage 1 occupancy
      if (req_acc)
         s1_valid_in = pt_valid || req_tlast;
      else if (s2_ready)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         vcnt_ff      <= '0;
         expect_y_ff  <= 1'b0;
         pending_x_ff <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         found_ff     <= 1'b0;
         min_x_ff     <= MIN_INIT;
         max_x_ff     <= MAX_INIT;
         min_y_ff     <= MIN_INIT;
         max_y_ff     <= MAX_INIT;
         overlong_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         accum_ff     <= accum_in;
         vcnt_ff      <= vcnt_in;
         expect_y_ff  <= expect_y_in;
         pending_x_ff <= pending_x_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         found_ff     <= found_in;
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         overlong_ff  <= overlong_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc)
         s1_ff <= s1_in;
   end

   // ---------------- verdict / output stage ----------------
   logic                      overlap, verdict;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]        rsp_x_ff, rsp_y_ff;
   logic                      rsp_pv_ff, rsp_done_ff, rsp_inside_ff, rsp_err_ff;
   logic                      s1_move;

   assign s1_move = s1_valid_ff && s2_ready;

   always_comb begin
      // bounding box against query box; runs even with no points decoded
      overlap = (s1_ff.max_x >= q_left_ff) && (s1_ff.min_x <= q_right_ff) &&
                (s1_ff.min_y <= q_bottom_ff) && (s1_ff.max_y >= q_top_ff);
      verdict = s1_ff.done && !s1_ff.err && (s1_ff.found || overlap);

      if (s1_move)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_x_ff      <= s1_ff.px;
         rsp_y_ff      <= s1_ff.py;
         rsp_pv_ff     <= s1_ff.pt_valid;
         rsp_done_ff   <= s1_ff.done;
         rsp_inside_ff <= verdict;
         rsp_err_ff    <= s1_ff.done && s1_ff.err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_err_ff, rsp_inside_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_pv_ff;
   assign rsp_tlast  = rsp_done_ff;

`ifndef SYNTHESIS
   // every beat carries a point, ends an object, or both
   a_beat_has_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser || rsp_tlast))
      else $error("rsp beat with neither point nor end of object");

   // verdict flags stay clear off the last beat and never both set
   a_flags_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[64] && rsp_tdata[65]) &&
                     (rsp_tlast || (!rsp_tdata[64] && !rsp_tdata[65])))
      else $error("inside/error flags inconsistent");

   // a final byte leaves the decoder at the start of a fresh object
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=>
         (vcnt_ff == '0) && !expect_y_ff && !overlong_ff && !found_ff)
      else $error("decode state not cleared after final byte");

   // x/y point fields are zero on a beat that carries no point
   a_no_point_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[63:0] == 64'd0))
      else $error("point fields nonzero without point_valid");
`endif

endmodule

`default_nettype wire
